// ===== rtl/gwm_pkg.sv =====
// Shared types and constants for the gravity well mesh deformer.
`timescale 1ns / 1ps
package gwm_pkg;

  localparam int MAX_BODIES = 64;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int NUM_REGS   = 6;

  // Commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_VERTEX = 2'd2;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MASS_THR,
    REG_WELL_SCALE,
    REG_MAX_DEPTH,
    REG_HORIZON,
    REG_DIMPLE,
    REG_INFLUENCE
  } reg_idx_e;

  // One body table entry
  typedef struct packed {
    logic        heavy;
    logic [31:0] size;
    logic [31:0] pos_x;
    logic [31:0] pos_z;
  } body_t;

  localparam int BODY_W = $bits(body_t);

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_MULX,
    ST_MULZ,
    ST_DIST,
    ST_SQWAIT,
    ST_DVWAIT,
    ST_BRANCH,
    ST_HSQ,
    ST_HMULQ,
    ST_HDIV,
    ST_HMAG,
    ST_PINF,
    ST_PUQ,
    ST_PMULU,
    ST_PTERM,
    ST_EMUL,
    ST_EDIV,
    ST_ESUM,
    ST_PMULP,
    ST_PPHI,
    ST_PPLO,
    ST_PMAG,
    ST_ACC,
    ST_NORM,
    ST_NQ,
    ST_FIN
  } st_e;

endpackage

// ===== rtl/gwm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gravity_well_mesh_deformer_top.sv =====
// Top level: body table RAM, sequencer and shared multiply/divide/root units.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o | cmd, body_*, vertex_*
//  out     | output    | out_valid_o/out_ready_i | touched, depth_out, red/green/blue
//  config  | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// Clear and add finish when accepted. A vertex walks the stored bodies one at a
// time through one 32x32 multiplier, a bit-serial divider and a bit-serial root;
// the 16-term exponential of a planet uses the divider once per term, and the
// colour takes one more division.
// Reset empties the table and restores the register defaults; no clearing pass.
// A finished result waits in the output register while the next transfer is taken.
`timescale 1ns / 1ps
module gravity_well_mesh_deformer_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  logic signed [31:0]   body_mass_i,
  input  logic [30:0]          body_radius_i,
  input  logic signed [31:0]   body_x_i,
  input  logic signed [31:0]   body_z_i,
  input  logic signed [31:0]   vertex_x_i,
  input  logic signed [31:0]   vertex_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 touched_o,
  output logic signed [31:0]   depth_out_o,
  output logic [15:0]          red_o,
  output logic [15:0]          green_o,
  output logic [15:0]          blue_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import gwm_pkg::*;

  // configuration registers
  logic [30:0] cfg_q [NUM_REGS];
  logic        cfg_we;
  reg_idx_e    cfg_idx;

  // control
  st_e              state_q, state_d, ret_q, ret_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] idx_q;
  logic             empty_q;
  logic             out_valid_q;
  logic             accept;
  logic             out_load;

  // table
  body_t            wr_entry, rd_entry;
  logic             ram_we;

  // datapath registers
  logic [31:0] vx_q, vz_q;
  logic        heavy_q;
  logic [31:0] size_q;
  logic [31:0] ax_q, az_q;
  logic [63:0] sx_q;
  logic [31:0] r_q;
  logic [33:0] den_q;
  logic [16:0] u_q;
  logic [30:0] x_q;
  logic [30:0] term_q;
  logic signed [33:0] sum_q;
  logic [4:0]  k_q;
  logic [30:0] g_q;
  logic [46:0] p_q;
  logic [47:0] a_q;
  logic [30:0] m_q;
  logic [30:0] total_q;
  logic [16:0] n_q;

  // output register
  logic        touched_q;
  logic [31:0] depth_q;
  logic [15:0] red_q, green_q, blue_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p_q;

  // bit-serial root
  logic        sq_start;
  logic [63:0] sq_arg;
  logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
  logic [63:0] sq_try;

  // bit-serial divider
  logic        dv_start;
  logic [67:0] dv_dvd;
  logic [46:0] dv_den;
  logic [6:0]  dv_n;
  logic [67:0] dv_num_q, dv_quo_q;
  logic [47:0] dv_rem_q, dv_rem_sh;
  logic [46:0] dv_den_q;
  logic [6:0]  dv_cnt_q;
  logic        dv_ge;

  // combinational helpers
  logic [32:0] dx, dz;
  logic [31:0] r_w;
  logic [32:0] horizon;
  logic [46:0] infl_w;
  logic [67:0] q10;
  logic [30:0] g_w;
  logic [48:0] pm_w;
  logic [31:0] tot_sum;
  logic [30:0] quo_cl;
  logic [32:0] red_p, green_p, blue_p;
  logic [16:0] blue_w;

  // ---------------------------------------------------------------- config
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_MASS_THR]   <= 31'd32768;
      cfg_q[REG_WELL_SCALE] <= 31'd52429;
      cfg_q[REG_MAX_DEPTH]  <= 31'd6553600;
      cfg_q[REG_HORIZON]    <= 31'd32768;
      cfg_q[REG_DIMPLE]     <= 31'd327680;
      cfg_q[REG_INFLUENCE]  <= 31'd524288;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MASS_THR:   cfg_q[REG_MASS_THR]   <= pwdata[30:0];
        REG_WELL_SCALE: cfg_q[REG_WELL_SCALE] <= pwdata[30:0];
        REG_MAX_DEPTH:  cfg_q[REG_MAX_DEPTH]  <= pwdata[30:0];
        REG_HORIZON:    cfg_q[REG_HORIZON]    <= pwdata[30:0];
        REG_DIMPLE:     cfg_q[REG_DIMPLE]     <= pwdata[30:0];
        REG_INFLUENCE:  cfg_q[REG_INFLUENCE]  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_MASS_THR:   prdata = {1'b0, cfg_q[REG_MASS_THR]};
      REG_WELL_SCALE: prdata = {1'b0, cfg_q[REG_WELL_SCALE]};
      REG_MAX_DEPTH:  prdata = {1'b0, cfg_q[REG_MAX_DEPTH]};
      REG_HORIZON:    prdata = {1'b0, cfg_q[REG_HORIZON]};
      REG_DIMPLE:     prdata = {1'b0, cfg_q[REG_DIMPLE]};
      REG_INFLUENCE:  prdata = {1'b0, cfg_q[REG_INFLUENCE]};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- table
  assign accept = in_valid_i & in_ready_o;
  assign ram_we = accept && (cmd_i == CMD_ADD) && !body_mass_i[31]
                  && (body_mass_i != '0) && (count_q < CNT_W'(MAX_BODIES));

  always_comb begin
    wr_entry.heavy = (body_mass_i[30:0] >= cfg_q[REG_MASS_THR]);
    wr_entry.size  = wr_entry.heavy ? {body_mass_i[30:0], 1'b0} : {1'b0, body_radius_i};
    wr_entry.pos_x = body_x_i;
    wr_entry.pos_z = body_z_i;
  end

  gwm_ram #(
    .WIDTH (BODY_W),
    .DEPTH (MAX_BODIES)
  ) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  // ---------------------------------------------------------------- helpers
  assign dx      = {vx_q[31], vx_q} - {rd_entry.pos_x[31], rd_entry.pos_x};
  assign dz      = {vz_q[31], vz_q} - {rd_entry.pos_z[31], rd_entry.pos_z};
  assign r_w     = sq_res_q[31:0];
  assign horizon = {1'b0, size_q} + {2'b0, cfg_q[REG_HORIZON]};
  assign infl_w  = mul_p_q[62:16];
  assign q10     = {1'b0, mul_p_q, 3'b0} + {3'b0, mul_p_q, 1'b0};
  assign pm_w    = {1'b0, a_q} + {15'b0, mul_p_q[63:30]};
  assign tot_sum = {1'b0, total_q} + {1'b0, m_q};
  assign quo_cl  = (dv_quo_q > {37'b0, cfg_q[REG_MAX_DEPTH]}) ? cfg_q[REG_MAX_DEPTH]
                                                               : dv_quo_q[30:0];

  // exponential sum limited to [0, 1]
  always_comb begin
    if (sum_q < 0) begin
      g_w = '0;
    end else if (sum_q > 34'sd1073741824) begin
      g_w = 31'd1073741824;
    end else begin
      g_w = sum_q[30:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    sq_start = 1'b0;
    sq_arg   = mul_p_q;
    dv_start = 1'b0;
    dv_dvd   = '0;
    dv_den   = '0;
    dv_n     = '0;
    mul_a    = '0;
    mul_b    = '0;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_VERTEX) begin
          state_d = (count_q == '0) ? ST_FIN : ST_LOAD;
        end
      end
      ST_LOAD: state_d = ST_READ;
      ST_READ: state_d = ST_MULX;
      ST_MULX: begin
        mul_a   = ax_q;
        mul_b   = ax_q;
        state_d = ST_MULZ;
      end
      ST_MULZ: begin
        mul_a   = az_q;
        mul_b   = az_q;
        state_d = ST_DIST;
      end
      ST_DIST: begin
        sq_start = 1'b1;
        sq_arg   = ({1'b0, sx_q} + {1'b0, mul_p_q} > 65'h0_FFFF_FFFF_FFFF_FFFF)
                   ? '1 : sx_q + mul_p_q;
        ret_d    = ST_BRANCH;
        state_d  = ST_SQWAIT;
      end
      ST_SQWAIT: begin
        if (sq_bit_q == '0) begin
          state_d = ret_q;
        end
      end
      ST_DVWAIT: begin
        if (dv_cnt_q == '0) begin
          state_d = ret_q;
        end
      end
      ST_BRANCH: begin
        if (size_q == '0) begin
          state_d = ST_ACC;
        end else if (heavy_q) begin
          if ({1'b0, r_w} <= horizon) begin
            state_d = ST_ACC;
          end else begin
            mul_a   = size_q;
            mul_b   = r_w - size_q;
            state_d = ST_HSQ;
          end
        end else begin
          mul_a   = size_q;
          mul_b   = {1'b0, cfg_q[REG_INFLUENCE]};
          state_d = ST_PINF;
        end
      end
      ST_HSQ: begin
        sq_start = 1'b1;
        ret_d    = ST_HMULQ;
        state_d  = ST_SQWAIT;
      end
      ST_HMULQ: begin
        mul_a   = {1'b0, cfg_q[REG_WELL_SCALE]};
        mul_b   = size_q;
        state_d = ST_HDIV;
      end
      ST_HDIV: begin
        dv_start = 1'b1;
        dv_dvd   = {q10[66:0], 1'b0};
        dv_den   = {13'b0, den_q};
        dv_n     = 7'd67;
        ret_d    = ST_HMAG;
        state_d  = ST_DVWAIT;
      end
      ST_HMAG: state_d = ST_ACC;
      ST_PINF: begin
        if ({15'b0, r_q} > infl_w) begin
          state_d = ST_ACC;
        end else if (infl_w == '0) begin
          state_d = ST_PMULU;
        end else begin
          dv_start = 1'b1;
          dv_dvd   = {r_q, 36'b0};
          dv_den   = infl_w;
          dv_n     = 7'd48;
          ret_d    = ST_PUQ;
          state_d  = ST_DVWAIT;
        end
      end
      ST_PUQ: state_d = ST_PMULU;
      ST_PMULU: begin
        mul_a   = {15'b0, u_q};
        mul_b   = {15'b0, u_q};
        state_d = ST_PTERM;
      end
      ST_PTERM: state_d = ST_EMUL;
      ST_EMUL: begin
        mul_a   = {1'b0, term_q};
        mul_b   = {1'b0, x_q};
        state_d = ST_EDIV;
      end
      ST_EDIV: begin
        dv_start = 1'b1;
        dv_dvd   = {mul_p_q[60:30], 37'b0};
        dv_den   = {42'b0, k_q};
        dv_n     = 7'd31;
        ret_d    = ST_ESUM;
        state_d  = ST_DVWAIT;
      end
      ST_ESUM: state_d = (k_q == 5'd16) ? ST_PMULP : ST_EMUL;
      ST_PMULP: begin
        mul_a   = size_q;
        mul_b   = {1'b0, cfg_q[REG_DIMPLE]};
        state_d = ST_PPHI;
      end
      ST_PPHI: begin
        mul_a   = {15'b0, mul_p_q[62:46]};
        mul_b   = {1'b0, g_q};
        state_d = ST_PPLO;
      end
      ST_PPLO: begin
        mul_a   = {2'b0, p_q[29:0]};
        mul_b   = {1'b0, g_q};
        state_d = ST_PMAG;
      end
      ST_PMAG: state_d = ST_ACC;
      ST_ACC: begin
        state_d = (idx_q + 1'b1 == count_q) ? ST_NORM : ST_LOAD;
      end
      ST_NORM: begin
        if (cfg_q[REG_MAX_DEPTH] == '0) begin
          state_d = ST_FIN;
        end else begin
          dv_start = 1'b1;
          dv_dvd   = {total_q, 37'b0};
          dv_den   = {16'b0, cfg_q[REG_MAX_DEPTH]};
          dv_n     = 7'd47;
          ret_d    = ST_NQ;
          state_d  = ST_DVWAIT;
        end
      end
      ST_NQ: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      if (accept) begin
        if (cmd_i == CMD_CLEAR) begin
          count_q <= '0;
        end else if (ram_we) begin
          count_q <= count_q + 1'b1;
        end
        idx_q   <= '0;
        empty_q <= (count_q == '0);
      end else if (state_q == ST_ACC) begin
        idx_q <= idx_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_a * mul_b;
    unique case (state_q)
      ST_IDLE: begin
        vx_q    <= vertex_x_i;
        vz_q    <= vertex_z_i;
        total_q <= '0;
        n_q     <= '0;
      end
      ST_READ: begin
        heavy_q <= rd_entry.heavy;
        size_q  <= rd_entry.size;
        ax_q    <= dx[32] ? 32'(-dx) : dx[31:0];
        az_q    <= dz[32] ? 32'(-dz) : dz[31:0];
        m_q     <= '0;
      end
      ST_MULZ: sx_q <= mul_p_q;
      ST_BRANCH: begin
        r_q <= r_w;
        if (heavy_q && size_q != '0 && {1'b0, r_w} <= horizon) begin
          m_q <= cfg_q[REG_MAX_DEPTH];
        end
      end
      ST_HMULQ: den_q <= {1'b0, sq_res_q[31:0], 1'b0} + 34'd65536;
      ST_HMAG:  m_q   <= quo_cl;
      ST_PINF: begin
        u_q <= '0;
      end
      ST_PUQ:   u_q <= dv_quo_q[16:0];
      ST_PTERM: begin
        x_q    <= {mul_p_q[32:16], 14'b0};
        term_q <= 31'd1073741824;
        sum_q  <= 34'sd1073741824;
        k_q    <= 5'd1;
      end
      ST_ESUM: begin
        term_q <= dv_quo_q[30:0];
        if (k_q[0]) begin
          sum_q <= sum_q - $signed({3'b0, dv_quo_q[30:0]});
        end else begin
          sum_q <= sum_q + $signed({3'b0, dv_quo_q[30:0]});
        end
        k_q <= k_q + 1'b1;
      end
      ST_PMULP: g_q <= g_w;
      ST_PPHI:  p_q <= mul_p_q[62:16];
      ST_PPLO:  a_q <= mul_p_q[47:0];
      ST_PMAG: begin
        m_q <= (pm_w > {18'b0, cfg_q[REG_MAX_DEPTH]}) ? cfg_q[REG_MAX_DEPTH] : pm_w[30:0];
      end
      ST_ACC: begin
        total_q <= (tot_sum > {1'b0, cfg_q[REG_MAX_DEPTH]}) ? cfg_q[REG_MAX_DEPTH]
                                                            : tot_sum[30:0];
      end
      ST_NQ: n_q <= dv_quo_q[16:0];
      default: ;
    endcase
  end

  // square root: one result bit a cycle
  assign sq_try = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_bit_q <= '0;
    end else if (sq_start) begin
      sq_bit_q <= 64'd1 << 62;
    end else if (sq_bit_q != '0) begin
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_v_q   <= sq_arg;
      sq_res_q <= '0;
    end else if (sq_bit_q != '0) begin
      if (sq_v_q >= sq_try) begin
        sq_v_q   <= sq_v_q - sq_try;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
    end
  end

  // restoring divider: one quotient bit a cycle, dividend left-aligned
  assign dv_rem_sh = {dv_rem_q[46:0], dv_num_q[67]};
  assign dv_ge     = (dv_rem_sh >= {1'b0, dv_den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_cnt_q <= '0;
    end else if (dv_start) begin
      dv_cnt_q <= dv_n;
    end else if (dv_cnt_q != '0) begin
      dv_cnt_q <= dv_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_start) begin
      dv_num_q <= dv_dvd;
      dv_den_q <= dv_den;
      dv_rem_q <= '0;
      dv_quo_q <= '0;
    end else if (dv_cnt_q != '0) begin
      dv_num_q <= {dv_num_q[66:0], 1'b0};
      dv_rem_q <= dv_ge ? dv_rem_sh - {1'b0, dv_den_q} : dv_rem_sh;
      dv_quo_q <= {dv_quo_q[66:0], dv_ge};
    end
  end

  // ---------------------------------------------------------------- output
  assign red_p   = 33'd45875 * {16'b0, n_q};
  assign green_p = 33'd52429 * {16'b0, n_q};
  assign blue_p  = red_p;
  assign blue_w  = 17'd65536 - blue_p[32:16];

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (empty_q) begin
        touched_q <= 1'b0;
        depth_q   <= '0;
        red_q     <= '0;
        green_q   <= '0;
        blue_q    <= '0;
      end else begin
        touched_q <= 1'b1;
        depth_q   <= 32'd0 - {1'b0, total_q};
        red_q     <= 16'(17'd13107 + red_p[32:16]);
        green_q   <= 16'(17'd58982 - green_p[32:16]);
        blue_q    <= blue_w[16] ? 16'hFFFF : blue_w[15:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign touched_o   = touched_q;
  assign depth_out_o = depth_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule
